@@ rtl/crpt_pkg.sv @@
`timescale 1ns / 1ps

package crpt_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int MAX_MERGED    = 15;
	localparam int ADDRESS_BITS  = 48;

	localparam int FIELD_W   = 48;
	localparam int MIN_SHIFT = 4;
	localparam int MAX_SHIFT = 12;
	localparam int BLK_W     = FIELD_W - MIN_SHIFT;
	localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int REL_W     = 4;
	localparam int CNT_RAW_W = $clog2(MAX_MERGED + 1);
	localparam int CNT_W     = (CNT_RAW_W > REL_W) ? CNT_RAW_W : REL_W;
	localparam int OCC_OUT_W = 6;
	localparam int LIM_W     = 6;
	localparam int OCC_RAW_W = $clog2(TABLE_ENTRIES + 1);
	localparam int OCC_W     = (OCC_RAW_W > LIM_W) ? OCC_RAW_W : LIM_W;
	localparam int SHIFT_W   = 4;

	localparam logic [FIELD_W-1:0] ADDR_MASK = (ADDRESS_BITS >= FIELD_W) ? {FIELD_W{1'b1}} :
		((({{(FIELD_W-1){1'b0}}, 1'b1}) << ADDRESS_BITS) - {{(FIELD_W-1){1'b0}}, 1'b1});

	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 112;

	typedef enum logic [1:0] {
		CFG_BLOCK_OFFSET = 2'd0,
		CFG_OCC_LIMIT    = 2'd1,
		CFG_USE_PHYS     = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		OP_ENQUEUE  = 1'b0,
		OP_COMPLETE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_ALLOCATED = 3'd0,
		ST_COALESCED = 3'd1,
		ST_DROPPED   = 3'd2,
		ST_COMPLETED = 3'd3,
		ST_NO_MATCH  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_PREFETCHED = 2'd0,
		KIND_LOCAL_HIT  = 2'd1,
		KIND_FAULT      = 2'd2
	} kind_t;

	typedef struct packed {
		logic             en;
		op_t              op;
		logic [BLK_W-1:0] blk;
		logic [LIM_W-1:0] lim;
	} tbl_req_t;

	typedef struct packed {
		status_t          status;
		logic [REL_W-1:0] released;
		logic             sat;
		logic [OCC_W-1:0] occ;
	} tbl_rsp_t;

endpackage

@@ rtl/crpt_table.sv @@
`timescale 1ns / 1ps

module crpt_table import crpt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tbl_req_t req,
	output tbl_rsp_t rsp
);

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [BLK_W-1:0]         blk_q [TABLE_ENTRIES];
	logic [CNT_W-1:0]         cnt_q [TABLE_ENTRIES];
	logic [OCC_W-1:0]         count_q;

	logic [TABLE_ENTRIES-1:0] hit_vec;
	logic                     hit_any;
	logic [IDX_W-1:0]         hit_idx;
	logic                     free_any;
	logic [IDX_W-1:0]         free_idx;
	logic [CNT_W-1:0]         hit_cnt;
	logic [OCC_W-1:0]         lim_eff;
	logic                     do_alloc;
	logic                     do_inc;
	logic                     do_free;

	always_comb begin
		hit_any  = 1'b0;
		hit_idx  = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			hit_vec[i] = valid_q[i] && (blk_q[i] == req.blk);
			if (hit_vec[i]) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign hit_cnt = cnt_q[hit_idx];
	assign lim_eff = (OCC_W'(req.lim) > OCC_W'(TABLE_ENTRIES)) ? OCC_W'(TABLE_ENTRIES)
		: OCC_W'(req.lim);

	always_comb begin
		rsp.status   = ST_NO_MATCH;
		rsp.released = '0;
		rsp.sat      = 1'b0;
		rsp.occ      = count_q;
		do_alloc     = 1'b0;
		do_inc       = 1'b0;
		do_free      = 1'b0;
		case (req.op)
			OP_ENQUEUE: begin
				if (hit_any) begin
					rsp.status = ST_COALESCED;
					if (hit_cnt >= CNT_W'(MAX_MERGED))
						rsp.sat = 1'b1;
					else
						do_inc = 1'b1;
				end else if (count_q >= lim_eff || !free_any) begin
					rsp.status = ST_DROPPED;
				end else begin
					rsp.status = ST_ALLOCATED;
					do_alloc   = 1'b1;
					rsp.occ    = count_q + 1'b1;
				end
			end
			OP_COMPLETE: begin
				if (hit_any) begin
					rsp.status   = ST_COMPLETED;
					rsp.released = hit_cnt[REL_W-1:0];
					do_free      = 1'b1;
					if (count_q != '0)
						rsp.occ = count_q - 1'b1;
				end
			end
			default: rsp.status = ST_NO_MATCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (req.en) begin
			count_q <= rsp.occ;
			if (do_alloc)
				valid_q[free_idx] <= 1'b1;
			if (do_free)
				valid_q[hit_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.en && do_alloc) begin
			blk_q[free_idx] <= req.blk;
			cnt_q[free_idx] <= CNT_W'(1);
		end
		if (req.en && do_inc)
			cnt_q[hit_idx] <= hit_cnt + 1'b1;
	end

endmodule

@@ rtl/coalescing_prefetch_request_table.sv @@
`timescale 1ns / 1ps

// Coalescing prefetch request table.
// Input stream: s_tuser is the operation (enqueue or completion), s_tdata carries
// the request address, PC and the completion flags. Output stream: one result
// item per input item, m_tuser is the status, m_tdata the issue request, the
// released count and kind, the saturation flag and the occupancy afterwards.
// Configuration: cfg_we/cfg_index/cfg_data write block offset bits, occupancy
// limit and the physical flag; write only while no item is in flight.
// Path: an accepted item sits in the input register, where the 32-entry tag
// compare and the table update happen, and is loaded into the output register,
// which drives m_tdata, as soon as that register is empty or being read.
// Throughput: one item per cycle while the receiver takes the results.
// When the receiver stalls the result holds in the output register, the next
// item waits in the input register, and s_tready falls once both are full.
// Reset empties the table and both registers; the configuration returns to a
// 64-byte block, a limit of 32 and virtual issue.
module coalescing_prefetch_request_table import crpt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [5:0]             cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// request_address[47:0], request_pc[95:48], local_hit[96], fault[97]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// operation
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// issue_valid[0], issue_block_address[48:1], issue_pc[96:49], issue_physical[97],
	// released_count[101:98], completion_kind[103:102], merge_saturated[104],
	// occupancy[110:105]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// status
	output logic [2:0]             m_tuser
);

	logic [SHIFT_W-1:0]     block_offset_q;
	logic [LIM_W-1:0]       occ_limit_q;
	logic                   use_phys_q;

	logic                   valid_s1;
	logic [FIELD_W-1:0]     addr_s1;
	logic [FIELD_W-1:0]     pc_s1;
	logic                   lhit_s1;
	logic                   fault_s1;
	op_t                    op_s1;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	status_t                out_status_q;

	logic                   advance;
	logic [SHIFT_W-1:0]     shift;
	logic [FIELD_W-1:0]     addr_shifted;
	logic [BLK_W-1:0]       blk;
	logic [FIELD_W-1:0]     issue_addr;
	logic                   issue;
	kind_t                  kind;
	tbl_req_t               req;
	tbl_rsp_t               rsp;
	logic [OUT_TDATA_W-1:0] result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_offset_q <= SHIFT_W'(6);
			occ_limit_q    <= LIM_W'(32);
			use_phys_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCK_OFFSET: block_offset_q <= cfg_data[SHIFT_W-1:0];
				CFG_OCC_LIMIT:    occ_limit_q    <= cfg_data[LIM_W-1:0];
				CFG_USE_PHYS:     use_phys_q     <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			addr_s1  <= s_tdata[47:0] & ADDR_MASK;
			pc_s1    <= s_tdata[95:48];
			lhit_s1  <= s_tdata[96];
			fault_s1 <= s_tdata[97];
			op_s1    <= op_t'(s_tuser);
		end
	end

	always_comb begin
		if (block_offset_q < SHIFT_W'(MIN_SHIFT))
			shift = SHIFT_W'(MIN_SHIFT);
		else if (block_offset_q > SHIFT_W'(MAX_SHIFT))
			shift = SHIFT_W'(MAX_SHIFT);
		else
			shift = block_offset_q;
	end

	assign addr_shifted = addr_s1 >> shift;
	assign blk          = addr_shifted[BLK_W-1:0];
	assign issue_addr   = {{MIN_SHIFT{1'b0}}, blk} << shift;

	assign req.en  = advance;
	assign req.op  = op_s1;
	assign req.blk = blk;
	assign req.lim = occ_limit_q;

	crpt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign issue = (rsp.status == ST_ALLOCATED);

	always_comb begin
		if (rsp.status != ST_COMPLETED)
			kind = KIND_PREFETCHED;
		else if (fault_s1)
			kind = KIND_FAULT;
		else if (lhit_s1)
			kind = KIND_LOCAL_HIT;
		else
			kind = KIND_PREFETCHED;
	end

	always_comb begin
		result          = '0;
		result[0]       = issue;
		result[48:1]    = issue ? issue_addr : '0;
		result[96:49]   = issue ? pc_s1 : '0;
		result[97]      = issue && use_phys_q;
		result[101:98]  = rsp.released;
		result[103:102] = kind;
		result[104]     = rsp.sat;
		result[110:105] = rsp.occ[OCC_OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q   <= result;
			out_status_q <= rsp.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import crpt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int POOL_DEPTH  = 8;

	typedef struct packed {
		status_t          status;
		logic             issue;
		logic [47:0]      issue_addr;
		logic [47:0]      issue_pc;
		logic             issue_phys;
		logic [3:0]       released;
		kind_t            kind;
		logic             saturated;
		logic [5:0]       occupancy;
	} table_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	cfg_idx_t               cfg_index = CFG_BLOCK_OFFSET;
	logic [5:0]             cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [2:0]             m_tuser;

	// mirror of the table and its registers
	logic             tbl_valid [TABLE_ENTRIES] = '{default: 1'b0};
	logic [BLK_W-1:0] tbl_block [TABLE_ENTRIES];
	logic [3:0]       tbl_count [TABLE_ENTRIES];
	int               occ_now   = 0;
	logic [3:0]       shift_reg = 4'd6;
	logic [5:0]       limit_reg = 6'd32;
	logic             phys_reg  = 1'b0;

	table_result_t pending_results [$];
	logic [47:0]   addr_pool [$];
	int            fail_count  = 0;
	int            cycle_count = 0;
	int            rx_idle_pct = 0;
	int            rx_hold_len = 0;
	int            hold_left   = 0;

	coalescing_prefetch_request_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	// one item through the table: lookup, then coalesce, allocate, drop or free
	function automatic table_result_t apply_to_table(op_t op, logic [47:0] addr,
			logic [47:0] pc, logic lhit, logic fault);
		table_result_t    r;
		int               sh;
		int               lim;
		int               hit;
		int               slot;
		logic [BLK_W-1:0] blk;
		r    = '0;
		sh   = (shift_reg < MIN_SHIFT) ? MIN_SHIFT : (shift_reg > MAX_SHIFT) ? MAX_SHIFT
			: int'(shift_reg);
		blk  = BLK_W'(addr >> sh);
		hit  = -1;
		slot = -1;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (hit < 0 && tbl_valid[i] && tbl_block[i] == blk)
				hit = i;
			if (slot < 0 && !tbl_valid[i])
				slot = i;
		end
		if (op == OP_ENQUEUE) begin
			if (hit >= 0) begin
				r.status = ST_COALESCED;
				if (tbl_count[hit] >= MAX_MERGED)
					r.saturated = 1'b1;
				else
					tbl_count[hit]++;
			end else begin
				lim = (limit_reg > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(limit_reg);
				if (occ_now >= lim || slot < 0) begin
					r.status = ST_DROPPED;
				end else begin
					tbl_valid[slot] = 1'b1;
					tbl_block[slot] = blk;
					tbl_count[slot] = 4'd1;
					occ_now++;
					r.status     = ST_ALLOCATED;
					r.issue      = 1'b1;
					r.issue_addr = {{(FIELD_W-BLK_W){1'b0}}, blk} << sh;
					r.issue_pc   = pc;
					r.issue_phys = phys_reg;
				end
			end
		end else begin
			if (hit >= 0) begin
				r.status   = ST_COMPLETED;
				r.released = tbl_count[hit];
				r.kind     = fault ? KIND_FAULT : (lhit ? KIND_LOCAL_HIT : KIND_PREFETCHED);
				tbl_valid[hit] = 1'b0;
				if (occ_now > 0)
					occ_now--;
			end else begin
				r.status = ST_NO_MATCH;
			end
		end
		r.occupancy = 6'(occ_now);
		return r;
	endfunction

	function automatic bit field_ok(string name, logic [47:0] want, logic [47:0] got);
		if (got !== want) begin
			$display("%0t mismatch on %s: expected %h, got %h", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		if (rx_hold_len > 0) begin
			hold_left   = rx_hold_len;
			rx_hold_len = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		table_result_t want;
		bit            ok;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t result with nothing expected: status %h, tdata %h",
					$time, m_tuser, m_tdata);
				fail_count++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				ok   = 1'b1;
				ok &= field_ok("status", 48'(want.status), 48'(m_tuser));
				ok &= field_ok("issue_valid", 48'(want.issue), 48'(m_tdata[0]));
				ok &= field_ok("issue_block_address", want.issue_addr, m_tdata[48:1]);
				ok &= field_ok("issue_pc", want.issue_pc, m_tdata[96:49]);
				ok &= field_ok("issue_physical", 48'(want.issue_phys), 48'(m_tdata[97]));
				ok &= field_ok("released_count", 48'(want.released), 48'(m_tdata[101:98]));
				ok &= field_ok("completion_kind", 48'(want.kind), 48'(m_tdata[103:102]));
				ok &= field_ok("merge_saturated", 48'(want.saturated), 48'(m_tdata[104]));
				ok &= field_ok("occupancy", 48'(want.occupancy), 48'(m_tdata[110:105]));
				if (!ok)
					fail_count++;
			end
		end
	end

	task automatic send_item(op_t op, logic [47:0] addr, logic [47:0] pc,
			logic lhit, logic fault);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'b0, fault, lhit, pc, addr};
		do @(posedge clk); while (!s_tready);
		pending_results.insert(pending_results.size(),
			apply_to_table(op, addr, pc, lhit, fault));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(logic [5:0] shift_val, logic [5:0] limit_val,
			logic [5:0] phys_val);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BLOCK_OFFSET;
		cfg_data  <= shift_val;
		@(posedge clk);
		cfg_index <= CFG_OCC_LIMIT;
		cfg_data  <= limit_val;
		@(posedge clk);
		cfg_index <= CFG_USE_PHYS;
		cfg_data  <= phys_val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		shift_reg = shift_val[3:0];
		limit_reg = limit_val;
		phys_reg  = phys_val[0];
		@(posedge clk);
	endtask

	// empties the table: at the smallest block size a stored block number n
	// is hit by the address n << 4 whatever size it was stored with
	task automatic flush_table();
		wait_idle();
		set_config(6'(MIN_SHIFT), limit_reg, 6'(phys_reg));
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (tbl_valid[i])
				send_item(OP_COMPLETE, {tbl_block[i], 4'b0}, rand48(),
					1'($urandom_range(1)), 1'($urandom_range(1)));
		wait_idle();
	endtask

	task automatic test_merge_and_complete();
		logic [47:0] blk_a;
		blk_a       = 48'h1234_5678_9AC0;
		rx_idle_pct = 50;
		// count climbs to the maximum, the last enqueue finds it saturated
		for (int i = 0; i < 16; i++)
			send_item(OP_ENQUEUE, blk_a + 48'(i), (i == 0) ? '1 : rand48(), 1'b0, 1'b0);
		send_item(OP_COMPLETE, blk_a, '0, 1'b1, 1'b1);
		send_item(OP_ENQUEUE, '0, '0, 1'b1, 1'b1);
		send_item(OP_ENQUEUE, '1, '1, 1'b0, 1'b0);
		send_item(OP_COMPLETE, '1, '1, 1'b1, 1'b0);
		send_item(OP_COMPLETE, '0, '0, 1'b0, 1'b0);
		send_item(OP_COMPLETE, '0, '0, 1'b0, 1'b0);
		wait_idle();
	endtask

	task automatic test_config_corners();
		logic [47:0] addr_x;
		logic [47:0] addr_y;
		addr_x      = rand48();
		addr_y      = rand48();
		rx_idle_pct = 30;
		set_config(6'd12, 6'd0, 6'd1);
		send_item(OP_ENQUEUE, rand48(), rand48(), 1'b0, 1'b0);
		wait_idle();
		set_config(6'd12, 6'd2, 6'd1);
		send_item(OP_ENQUEUE, addr_x, rand48(), 1'b0, 1'b1);
		send_item(OP_ENQUEUE, addr_y, rand48(), 1'b1, 1'b0);
		send_item(OP_ENQUEUE, ~addr_y, rand48(), 1'b0, 1'b0);
		send_item(OP_ENQUEUE, addr_x ^ 48'hFFF, rand48(), 1'b0, 1'b0);
		wait_idle();
		// limit now below occupancy and block size below range; stored
		// numbers are matched unchanged against the new alignment
		set_config(6'd0, 6'd1, 6'd0);
		send_item(OP_ENQUEUE, rand48(), rand48(), 1'b0, 1'b0);
		send_item(OP_COMPLETE, {8'b0, addr_x[47:12], 4'b0}, '0, 1'b0, 1'b1);
		send_item(OP_ENQUEUE, rand48(), rand48(), 1'b0, 1'b0);
		send_item(OP_COMPLETE, addr_x, '0, 1'b0, 1'b0);
		flush_table();
	endtask

	task automatic test_input_backpressure();
		rx_idle_pct = 0;
		set_config(6'd15, 6'd63, 6'd0);
		rx_hold_len = 300;
		for (int i = 0; i < 40; i++)
			send_item(OP_ENQUEUE, rand48(), rand48(), 1'($urandom_range(1)),
				1'($urandom_range(1)));
		wait_idle();
		flush_table();
	endtask

	task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct);
		logic [5:0]  sv;
		logic [5:0]  lv;
		logic [47:0] a;
		logic [47:0] pc;
		int          pick;
		rx_idle_pct = rx_pct;
		for (int n = 0; n < n_items; n++) begin
			if (n % 155 == 0) begin
				wait_idle();
				case ($urandom_range(0, 5))
					0: sv = 6'd4;
					1: sv = 6'd12;
					2: sv = 6'($urandom_range(0, 3));
					3: sv = 6'($urandom_range(13, 15));
					default: sv = 6'($urandom_range(0, 63));
				endcase
				case ($urandom_range(0, 7))
					0: lv = 6'd0;
					1: lv = 6'($urandom_range(1, 4));
					2, 3: lv = 6'd32;
					4: lv = 6'($urandom_range(33, 63));
					default: lv = 6'($urandom_range(5, 31));
				endcase
				set_config(sv, lv, 6'($urandom_range(0, 63)));
			end
			while ($urandom_range(99) < tx_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			case ($urandom_range(0, 9))
				0: a = '1;
				1: a = 48'($urandom_range(0, 255));
				default: a = rand48();
			endcase
			pc   = ($urandom_range(0, 15) == 0) ? '1 : rand48();
			pick = $urandom_range(99);
			if (addr_pool.size() != 0 && pick < 40) begin
				// same block, other low bits
				a = addr_pool[$urandom_range(0, addr_pool.size() - 1)] ^ 48'($urandom_range(0, 15));
				send_item(OP_ENQUEUE, a, pc, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end else if (pick < 65 || addr_pool.size() == 0) begin
				addr_pool.insert(addr_pool.size(), a);
				if (addr_pool.size() > POOL_DEPTH)
					addr_pool.delete(0);
				send_item(OP_ENQUEUE, a, pc, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end else if (pick < 95) begin
				a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
				send_item(OP_COMPLETE, a, pc, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end else begin
				send_item(OP_COMPLETE, a, pc, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end
		end
		wait_idle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_merge_and_complete();
		test_config_corners();
		test_input_backpressure();
		test_random_traffic(617, 16, 86);
		test_random_traffic(617, 86, 16);
		test_random_traffic(616, 0, 0);
		wait_idle();
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
